### design/ptstat_pkg.sv
// Shared types, constants and helpers for the per-MAC and IP traffic statistics block.
`default_nettype none

package ptstat_pkg;

    // Table sizes
    localparam int MAC_ENTRIES = 64;
    localparam int IP_ENTRIES  = 64;

    localparam int MAC_IDX_W  = $clog2(MAC_ENTRIES);
    localparam int IP_IDX_W   = $clog2(IP_ENTRIES);
    localparam int MAC_FILL_W = $clog2(MAC_ENTRIES + 1);
    localparam int IP_FILL_W  = $clog2(IP_ENTRIES + 1);

    // Width used to compare a read index against a fill level
    localparam int CMP_W = 11;

    // Stream widths
    localparam int IN_DATA_W  = 160;
    localparam int OUT_DATA_W = 176;

    // Storage widths
    localparam int MAC_W     = 48;
    localparam int IP_W      = 32;
    localparam int COUNT_W   = 32;
    localparam int MAC_RAM_W = MAC_W + COUNT_W;

    // Item kinds
    localparam logic [1:0] KIND_HEADER   = 2'd0;
    localparam logic [1:0] KIND_READ_MAC = 2'd1;
    localparam logic [1:0] KIND_READ_IP  = 2'd2;

    // Header constants
    localparam logic [15:0] MIN_HEADER_BYTES = 16'd14;
    localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
    localparam logic [7:0]  PROTO_TCP        = 8'd6;
    localparam logic [7:0]  PROTO_UDP        = 8'd17;

    // Bits of full_flags
    localparam int FULL_MAC_BIT = 0;
    localparam int FULL_IP_BIT  = 1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] frame_length;
        logic [47:0] src_mac;
        logic [15:0] eth_type;
        logic [31:0] ip_source;
        logic [31:0] ip_dest;
        logic [7:0]  ip_protocol;
        logic [5:0]  read_index;
    } item_t;

    typedef struct packed {
        logic        short_frame;
        logic [5:0]  mac_slot;
        logic [31:0] mac_packets;
        logic        mac_is_new;
        logic        src_ip_is_new;
        logic        dst_ip_is_new;
        logic [6:0]  distinct_macs;
        logic [6:0]  distinct_ips;
        logic [31:0] tcp_total;
        logic [31:0] udp_total;
        logic [47:0] entry_value;
        logic [1:0]  full_flags;
    } result_t;

    // One MAC table word: address and packet count
    typedef struct packed {
        logic [MAC_W-1:0]   mac;
        logic [COUNT_W-1:0] count;
    } mac_entry_t;

    // Port requests toward each table memory
    typedef struct packed {
        logic                 we;
        logic [MAC_IDX_W-1:0] waddr;
        mac_entry_t           wdata;
        logic [MAC_IDX_W-1:0] raddr;
    } mac_ram_req_t;

    typedef struct packed {
        logic                we;
        logic [IP_IDX_W-1:0] waddr;
        logic [IP_W-1:0]     wdata;
        logic [IP_IDX_W-1:0] raddr;
    } ip_ram_req_t;

    // Saturating increment
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        sat_inc = (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
    endfunction

endpackage

`default_nettype wire

### design/ptstat_ram.sv
// Simple dual-port RAM: one write port, one read port with registered read data.
`default_nettype none

module ptstat_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### design/ptstat_engine.sv
// Sequencer that scans, updates and reads the MAC table and IP set memories.
`default_nettype none

module ptstat_engine (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire ptstat_pkg::item_t       in_item,
    output logic                         res_valid,
    input  wire logic                    res_ready,
    output ptstat_pkg::result_t          res,
    output ptstat_pkg::mac_ram_req_t     mac_req,
    input  wire ptstat_pkg::mac_entry_t  mac_rdata,
    output ptstat_pkg::ip_ram_req_t      ip_req,
    input  wire logic [ptstat_pkg::IP_W-1:0] ip_rdata
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC_RD,
        ST_MAC_CMP,
        ST_MAC_MISS,
        ST_IP_START,
        ST_IP_RD,
        ST_IP_CMP,
        ST_IP_MISS,
        ST_COUNT,
        ST_RD_ISSUE,
        ST_RD_DATA,
        ST_DONE
    } state_t;

    state_t                                   state_reg;
    ptstat_pkg::item_t                        item_reg;
    ptstat_pkg::result_t                      res_reg;
    logic [ptstat_pkg::MAC_IDX_W-1:0]         mac_idx_reg;
    logic [ptstat_pkg::IP_IDX_W-1:0]          ip_idx_reg;
    logic                                     ip_sel_reg;
    logic [ptstat_pkg::MAC_FILL_W-1:0]        mac_fill_reg;
    logic [ptstat_pkg::IP_FILL_W-1:0]         ip_fill_reg;
    logic [ptstat_pkg::COUNT_W-1:0]           tcp_reg;
    logic [ptstat_pkg::COUNT_W-1:0]           udp_reg;

    logic                                     is_ipv4;
    logic [ptstat_pkg::IP_W-1:0]              ip_addr;
    logic                                     mac_hit;
    logic                                     mac_last;
    logic                                     mac_room;
    logic                                     ip_hit;
    logic                                     ip_last;
    logic                                     ip_room;
    logic [ptstat_pkg::COUNT_W-1:0]           mac_count_inc;

    // Decode of the captured item and the current scan position
    always_comb
    begin
        is_ipv4       = (item_reg.eth_type == ptstat_pkg::ETHERTYPE_IPV4);
        ip_addr       = ip_sel_reg ? item_reg.ip_dest : item_reg.ip_source;
        mac_hit       = (mac_rdata.mac == item_reg.src_mac);
        mac_last      = ((ptstat_pkg::MAC_FILL_W'(mac_idx_reg) + ptstat_pkg::MAC_FILL_W'(1))
                         == mac_fill_reg);
        mac_room      = (mac_fill_reg < ptstat_pkg::MAC_FILL_W'(ptstat_pkg::MAC_ENTRIES));
        ip_hit        = (ip_rdata == ip_addr);
        ip_last       = ((ptstat_pkg::IP_FILL_W'(ip_idx_reg) + ptstat_pkg::IP_FILL_W'(1))
                         == ip_fill_reg);
        ip_room       = (ip_fill_reg < ptstat_pkg::IP_FILL_W'(ptstat_pkg::IP_ENTRIES));
        mac_count_inc = ptstat_pkg::sat_inc(mac_rdata.count);
    end

    // Memory requests
    always_comb
    begin
        mac_req.raddr       = mac_idx_reg;
        mac_req.we          = ((state_reg == ST_MAC_CMP) && mac_hit) ||
                              ((state_reg == ST_MAC_MISS) && mac_room);
        mac_req.waddr       = (state_reg == ST_MAC_CMP) ? mac_idx_reg
                              : mac_fill_reg[ptstat_pkg::MAC_IDX_W-1:0];
        mac_req.wdata.mac   = item_reg.src_mac;
        mac_req.wdata.count = (state_reg == ST_MAC_CMP) ? mac_count_inc
                              : ptstat_pkg::COUNT_W'(1);

        ip_req.raddr = ip_idx_reg;
        ip_req.we    = (state_reg == ST_IP_MISS) && ip_room;
        ip_req.waddr = ip_fill_reg[ptstat_pkg::IP_IDX_W-1:0];
        ip_req.wdata = ip_addr;
    end

    // Handshakes and result with the current totals
    always_comb
    begin
        in_ready          = (state_reg == ST_IDLE);
        res_valid         = (state_reg == ST_DONE);
        res               = res_reg;
        res.distinct_macs = 7'(mac_fill_reg);
        res.distinct_ips  = 7'(ip_fill_reg);
        res.tcp_total     = tcp_reg;
        res.udp_total     = udp_reg;
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            item_reg     <= '0;
            res_reg      <= '0;
            mac_idx_reg  <= '0;
            ip_idx_reg   <= '0;
            ip_sel_reg   <= 1'b0;
            mac_fill_reg <= '0;
            ip_fill_reg  <= '0;
            tcp_reg      <= '0;
            udp_reg      <= '0;
        end
        else
        begin
            unique case (state_reg)
                // res_reg is already clear here
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg <= in_item;
                        unique case (in_item.kind)
                            ptstat_pkg::KIND_HEADER:
                            begin
                                if (in_item.frame_length < ptstat_pkg::MIN_HEADER_BYTES)
                                begin
                                    res_reg.short_frame <= 1'b1;
                                    state_reg           <= ST_DONE;
                                end
                                else if (mac_fill_reg == '0)
                                begin
                                    state_reg <= ST_MAC_MISS;
                                end
                                else
                                begin
                                    mac_idx_reg <= '0;
                                    state_reg   <= ST_MAC_RD;
                                end
                            end
                            ptstat_pkg::KIND_READ_MAC:
                            begin
                                res_reg.mac_slot <= in_item.read_index;
                                mac_idx_reg <= ptstat_pkg::MAC_IDX_W'(in_item.read_index);
                                if (ptstat_pkg::CMP_W'(in_item.read_index)
                                    < ptstat_pkg::CMP_W'(mac_fill_reg))
                                begin
                                    state_reg <= ST_RD_ISSUE;
                                end
                                else
                                begin
                                    state_reg <= ST_DONE;
                                end
                            end
                            ptstat_pkg::KIND_READ_IP:
                            begin
                                res_reg.mac_slot <= in_item.read_index;
                                ip_idx_reg <= ptstat_pkg::IP_IDX_W'(in_item.read_index);
                                if (ptstat_pkg::CMP_W'(in_item.read_index)
                                    < ptstat_pkg::CMP_W'(ip_fill_reg))
                                begin
                                    state_reg <= ST_RD_ISSUE;
                                end
                                else
                                begin
                                    state_reg <= ST_DONE;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end

                // MAC table scan: read an entry, then compare it
                ST_MAC_RD:
                begin
                    state_reg <= ST_MAC_CMP;
                end

                ST_MAC_CMP:
                begin
                    if (mac_hit)
                    begin
                        res_reg.mac_slot    <= 6'(mac_idx_reg);
                        res_reg.mac_packets <= mac_count_inc;
                        ip_sel_reg          <= 1'b0;
                        state_reg           <= is_ipv4 ? ST_IP_START : ST_DONE;
                    end
                    else if (mac_last)
                    begin
                        state_reg <= ST_MAC_MISS;
                    end
                    else
                    begin
                        mac_idx_reg <= mac_idx_reg + ptstat_pkg::MAC_IDX_W'(1);
                        state_reg   <= ST_MAC_RD;
                    end
                end

                // Absent MAC: take the next free slot, or flag the drop
                ST_MAC_MISS:
                begin
                    if (mac_room)
                    begin
                        res_reg.mac_slot    <= 6'(mac_fill_reg);
                        res_reg.mac_packets <= ptstat_pkg::COUNT_W'(1);
                        res_reg.mac_is_new  <= 1'b1;
                        mac_fill_reg        <= mac_fill_reg + ptstat_pkg::MAC_FILL_W'(1);
                    end
                    else
                    begin
                        res_reg.full_flags[ptstat_pkg::FULL_MAC_BIT] <= 1'b1;
                    end
                    ip_sel_reg <= 1'b0;
                    state_reg  <= is_ipv4 ? ST_IP_START : ST_DONE;
                end

                // IP set scan for the source, then the destination
                ST_IP_START:
                begin
                    ip_idx_reg <= '0;
                    state_reg  <= (ip_fill_reg == '0) ? ST_IP_MISS : ST_IP_RD;
                end

                ST_IP_RD:
                begin
                    state_reg <= ST_IP_CMP;
                end

                ST_IP_CMP:
                begin
                    if (ip_hit)
                    begin
                        ip_sel_reg <= 1'b1;
                        state_reg  <= ip_sel_reg ? ST_COUNT : ST_IP_START;
                    end
                    else if (ip_last)
                    begin
                        state_reg <= ST_IP_MISS;
                    end
                    else
                    begin
                        ip_idx_reg <= ip_idx_reg + ptstat_pkg::IP_IDX_W'(1);
                        state_reg  <= ST_IP_RD;
                    end
                end

                ST_IP_MISS:
                begin
                    if (ip_room)
                    begin
                        ip_fill_reg <= ip_fill_reg + ptstat_pkg::IP_FILL_W'(1);
                        if (ip_sel_reg)
                        begin
                            res_reg.dst_ip_is_new <= 1'b1;
                        end
                        else
                        begin
                            res_reg.src_ip_is_new <= 1'b1;
                        end
                    end
                    else
                    begin
                        res_reg.full_flags[ptstat_pkg::FULL_IP_BIT] <= 1'b1;
                    end
                    ip_sel_reg <= 1'b1;
                    state_reg  <= ip_sel_reg ? ST_COUNT : ST_IP_START;
                end

                // Protocol totals
                ST_COUNT:
                begin
                    if (item_reg.ip_protocol == ptstat_pkg::PROTO_TCP)
                    begin
                        tcp_reg <= ptstat_pkg::sat_inc(tcp_reg);
                    end
                    else if (item_reg.ip_protocol == ptstat_pkg::PROTO_UDP)
                    begin
                        udp_reg <= ptstat_pkg::sat_inc(udp_reg);
                    end
                    state_reg <= ST_DONE;
                end

                // Table reads
                ST_RD_ISSUE:
                begin
                    state_reg <= ST_RD_DATA;
                end

                ST_RD_DATA:
                begin
                    if (item_reg.kind == ptstat_pkg::KIND_READ_MAC)
                    begin
                        res_reg.mac_packets <= mac_rdata.count;
                        res_reg.entry_value <= mac_rdata.mac;
                    end
                    else
                    begin
                        res_reg.entry_value <= 48'(ip_rdata);
                    end
                    state_reg <= ST_DONE;
                end

                // Result taken: clear it for the next transaction
                ST_DONE:
                begin
                    if (res_ready)
                    begin
                        res_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### design/per_mac_ip_traffic_stats.sv
// Top level: stream ports, table memories, sequencer and output register.
//
// Counts packets per Ethernet source address in a MAC table and keeps a set of
// distinct IPv4 addresses with TCP and UDP totals; read transactions return
// stored entries. Both tables are synchronous RAMs searched linearly, each
// entry read and then compared; a non-IPv4 header skips the IP part. One
// transaction is worked on at a time; the result sits in an output register
// so the next input can be taken while it waits. No clearing pass is needed
// after reset: fill counters bound every search and read.
`default_nettype none

module per_mac_ip_traffic_stats (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // frame_length[15:0], src_mac[63:16], eth_type[79:64], ip_source[111:80],
    // ip_dest[143:112], ip_protocol[151:144], read_index[157:152], zero pad
    input  wire logic [ptstat_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // kind[1:0]
    input  wire logic [1:0]                         s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // mac_slot[5:0], mac_packets[37:6], mac_is_new[38], src_ip_is_new[39],
    // dst_ip_is_new[40], distinct_macs[47:41], distinct_ips[54:48],
    // tcp_total[86:55], udp_total[118:87], entry_value[166:119],
    // full_flags[168:167], zero pad
    output logic [ptstat_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // short_frame
    output logic                                    m_axis_tuser
);

    ptstat_pkg::item_t          in_item;
    ptstat_pkg::result_t        eng_res;
    ptstat_pkg::result_t        out_reg;
    ptstat_pkg::result_t        out_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       eng_res_valid;
    logic                       eng_res_ready;
    ptstat_pkg::mac_ram_req_t   mac_req;
    ptstat_pkg::mac_entry_t     mac_rdata;
    ptstat_pkg::ip_ram_req_t    ip_req;
    logic [ptstat_pkg::IP_W-1:0] ip_rdata;
    logic [ptstat_pkg::MAC_RAM_W-1:0] mac_rdata_raw;

    // Input unpacking
    always_comb
    begin
        in_item.kind         = s_axis_tuser;
        in_item.frame_length = s_axis_tdata[15:0];
        in_item.src_mac      = s_axis_tdata[63:16];
        in_item.eth_type     = s_axis_tdata[79:64];
        in_item.ip_source    = s_axis_tdata[111:80];
        in_item.ip_dest      = s_axis_tdata[143:112];
        in_item.ip_protocol  = s_axis_tdata[151:144];
        in_item.read_index   = s_axis_tdata[157:152];
    end

    ptstat_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .res_valid (eng_res_valid),
        .res_ready (eng_res_ready),
        .res       (eng_res),
        .mac_req   (mac_req),
        .mac_rdata (mac_rdata),
        .ip_req    (ip_req),
        .ip_rdata  (ip_rdata)
    );

    // MAC table: address and packet count per slot
    ptstat_ram #(
        .DEPTH (ptstat_pkg::MAC_ENTRIES),
        .WIDTH (ptstat_pkg::MAC_RAM_W)
    ) u_mac_ram (
        .clk   (clk),
        .we    (mac_req.we),
        .waddr (mac_req.waddr),
        .wdata (mac_req.wdata),
        .raddr (mac_req.raddr),
        .rdata (mac_rdata_raw)
    );

    assign mac_rdata = ptstat_pkg::mac_entry_t'(mac_rdata_raw);

    // IP address set
    ptstat_ram #(
        .DEPTH (ptstat_pkg::IP_ENTRIES),
        .WIDTH (ptstat_pkg::IP_W)
    ) u_ip_ram (
        .clk   (clk),
        .we    (ip_req.we),
        .waddr (ip_req.waddr),
        .wdata (ip_req.wdata),
        .raddr (ip_req.raddr),
        .rdata (ip_rdata)
    );

    // Output register between the sequencer and the master side
    always_comb
    begin
        eng_res_ready  = !out_valid_reg || m_axis_tready;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (eng_res_valid && eng_res_ready)
        begin
            out_next       = eng_res;
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // Output packing
    always_comb
    begin
        m_axis_tvalid = out_valid_reg;
        m_axis_tuser  = out_reg.short_frame;
        m_axis_tdata  = {7'd0,
                         out_reg.full_flags,
                         out_reg.entry_value,
                         out_reg.udp_total,
                         out_reg.tcp_total,
                         out_reg.distinct_ips,
                         out_reg.distinct_macs,
                         out_reg.dst_ip_is_new,
                         out_reg.src_ip_is_new,
                         out_reg.mac_is_new,
                         out_reg.mac_packets,
                         out_reg.mac_slot};
    end

endmodule

`default_nettype wire

### verif/per_mac_ip_traffic_stats_test.sv
// Self-checking testbench for the per-MAC packet counter and distinct IPv4 address set.
`timescale 1ns / 1ps

module per_mac_ip_traffic_stats_test;

    localparam logic [1:0]  KIND_UNUSED    = 2'd3;
    localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam int MAC_POOL     = 80;
    localparam int IP_POOL      = 96;
    localparam int PHASE_ITEMS  = 160;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 500;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [ptstat_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]                        s_tuser = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [ptstat_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                              m_tuser;

    per_mac_ip_traffic_stats dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    // Expected copy of the tables and totals
    logic [47:0] mac_addr [ptstat_pkg::MAC_ENTRIES];
    logic [31:0] mac_pkts [ptstat_pkg::MAC_ENTRIES];
    int          mac_used = 0;
    logic [31:0] ip_addr [ptstat_pkg::IP_ENTRIES];
    int          ip_used = 0;
    logic [31:0] tcp_pkts = '0;
    logic [31:0] udp_pkts = '0;

    // Address pools so that entries repeat and both tables run full
    logic [47:0] mac_pool [MAC_POOL];
    logic [31:0] ip_pool [IP_POOL];

    ptstat_pkg::item_t   pending_items[$];
    ptstat_pkg::result_t expected_stats[$];
    ptstat_pkg::item_t   presented_item;
    ptstat_pkg::item_t   next_item;
    ptstat_pkg::result_t got;
    ptstat_pkg::result_t want;
    int      send_idle = 13;
    int      recv_idle = 53;
    int      errors = 0;
    int      idle_cycles = 0;

    function automatic logic [31:0] count_up(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // Returns {dropped, inserted}
    function automatic logic [1:0] add_ip(input logic [31:0] a);
        int i;
        for (i = 0; i < ip_used; i++)
            if (ip_addr[i] == a)
                return 2'b00;
        if (ip_used >= ptstat_pkg::IP_ENTRIES)
            return 2'b10;
        ip_addr[ip_used] = a;
        ip_used++;
        return 2'b01;
    endfunction

    // Updates the expected state for one transaction and returns its result
    function automatic ptstat_pkg::result_t predict_stats(input ptstat_pkg::item_t it);
        ptstat_pkg::result_t r;
        int         i;
        logic       hit;
        logic [1:0] s;
        logic [1:0] d;
        r = '0;
        case (it.kind)
            ptstat_pkg::KIND_HEADER:
            begin
                if (it.frame_length < ptstat_pkg::MIN_HEADER_BYTES)
                begin
                    r.short_frame = 1'b1;
                end
                else
                begin
                    hit = 1'b0;
                    for (i = 0; i < mac_used; i++)
                    begin
                        if (!hit && mac_addr[i] == it.src_mac)
                        begin
                            hit = 1'b1;
                            mac_pkts[i] = count_up(mac_pkts[i]);
                            r.mac_slot = i[5:0];
                            r.mac_packets = mac_pkts[i];
                        end
                    end
                    if (!hit)
                    begin
                        if (mac_used < ptstat_pkg::MAC_ENTRIES)
                        begin
                            mac_addr[mac_used] = it.src_mac;
                            mac_pkts[mac_used] = 32'd1;
                            r.mac_slot = mac_used[5:0];
                            r.mac_packets = 32'd1;
                            r.mac_is_new = 1'b1;
                            mac_used++;
                        end
                        else
                        begin
                            r.full_flags[ptstat_pkg::FULL_MAC_BIT] = 1'b1;
                        end
                    end
                    if (it.eth_type == ptstat_pkg::ETHERTYPE_IPV4)
                    begin
                        s = add_ip(it.ip_source);
                        d = add_ip(it.ip_dest);
                        r.src_ip_is_new = s[0];
                        r.dst_ip_is_new = d[0];
                        r.full_flags[ptstat_pkg::FULL_IP_BIT] = s[1] | d[1];
                        if (it.ip_protocol == ptstat_pkg::PROTO_TCP)
                            tcp_pkts = count_up(tcp_pkts);
                        else if (it.ip_protocol == ptstat_pkg::PROTO_UDP)
                            udp_pkts = count_up(udp_pkts);
                    end
                end
            end
            ptstat_pkg::KIND_READ_MAC:
            begin
                r.mac_slot = it.read_index;
                if (it.read_index < mac_used)
                begin
                    r.mac_packets = mac_pkts[it.read_index];
                    r.entry_value = mac_addr[it.read_index];
                end
            end
            ptstat_pkg::KIND_READ_IP:
            begin
                r.mac_slot = it.read_index;
                if (it.read_index < ip_used)
                    r.entry_value = {16'h0, ip_addr[it.read_index]};
            end
            default:
            begin
            end
        endcase
        r.distinct_macs = mac_used[6:0];
        r.distinct_ips = ip_used[6:0];
        r.tcp_total = tcp_pkts;
        r.udp_total = udp_pkts;
        return r;
    endfunction

    // Mostly well-formed headers drawn from the pools, some noise and reads
    function automatic ptstat_pkg::item_t random_item();
        ptstat_pkg::item_t it;
        int    pick;
        it.kind = ptstat_pkg::KIND_HEADER;
        it.frame_length = 16'($urandom_range(1518, 14));
        it.src_mac = 48'({$urandom(), $urandom()});
        it.eth_type = ptstat_pkg::ETHERTYPE_IPV4;
        it.ip_source = $urandom();
        it.ip_dest = $urandom();
        it.ip_protocol = 8'($urandom_range(255));
        it.read_index = 6'($urandom_range(63));
        pick = $urandom_range(99);
        if (pick < 8)
            it.kind = ptstat_pkg::KIND_READ_MAC;
        else if (pick < 14)
            it.kind = ptstat_pkg::KIND_READ_IP;
        else if (pick < 16)
            it.kind = KIND_UNUSED;
        pick = $urandom_range(99);
        if (pick < 6)
            it.frame_length = 16'($urandom_range(13));
        else if (pick < 16)
            it.frame_length = 16'($urandom_range(16'hFFFF));
        if ($urandom_range(99) < 85)
            it.src_mac = mac_pool[$urandom_range(MAC_POOL - 1)];
        if ($urandom_range(99) < 25)
            it.eth_type = 16'($urandom_range(16'hFFFF));
        if ($urandom_range(99) < 85)
            it.ip_source = ip_pool[$urandom_range(IP_POOL - 1)];
        if ($urandom_range(99) < 85)
            it.ip_dest = ip_pool[$urandom_range(IP_POOL - 1)];
        if ($urandom_range(99) < 5)
            it.ip_dest = it.ip_source;
        pick = $urandom_range(99);
        if (pick < 40)
            it.ip_protocol = ptstat_pkg::PROTO_TCP;
        else if (pick < 75)
            it.ip_protocol = ptstat_pkg::PROTO_UDP;
        return it;
    endfunction

    task automatic add_header(input logic [15:0] len, input logic [47:0] mac,
                              input logic [15:0] etype, input logic [31:0] src,
                              input logic [31:0] dst, input logic [7:0] proto);
        ptstat_pkg::item_t it;
        it.kind = ptstat_pkg::KIND_HEADER;
        it.frame_length = len;
        it.src_mac = mac;
        it.eth_type = etype;
        it.ip_source = src;
        it.ip_dest = dst;
        it.ip_protocol = proto;
        it.read_index = 6'($urandom_range(63));
        pending_items.push_back(it);
    endtask

    task automatic add_read(input logic [1:0] k, input logic [5:0] idx);
        ptstat_pkg::item_t it;
        it = random_item();
        it.kind = k;
        it.read_index = idx;
        pending_items.push_back(it);
    endtask

    // Returns once everything queued has been sent and answered
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || s_tvalid || expected_stats.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t ns: %s expected %0h, actual %0h", $time, name, exp_val, act_val);
            errors++;
        end
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Input driver: one transaction per handshake, gaps at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_stats.push_back(predict_stats(presented_item));
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    next_item = pending_items.pop_front();
                    presented_item <= next_item;
                    s_tvalid <= 1'b1;
                    s_tuser <= next_item.kind;
                    s_tdata <= {2'b00, next_item.read_index, next_item.ip_protocol,
                                next_item.ip_dest, next_item.ip_source,
                                next_item.eth_type, next_item.src_mac,
                                next_item.frame_length};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Result monitor and checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got.short_frame   = m_tuser;
            got.mac_slot      = m_tdata[5:0];
            got.mac_packets   = m_tdata[37:6];
            got.mac_is_new    = m_tdata[38];
            got.src_ip_is_new = m_tdata[39];
            got.dst_ip_is_new = m_tdata[40];
            got.distinct_macs = m_tdata[47:41];
            got.distinct_ips  = m_tdata[54:48];
            got.tcp_total     = m_tdata[86:55];
            got.udp_total     = m_tdata[118:87];
            got.entry_value   = m_tdata[166:119];
            got.full_flags    = m_tdata[168:167];
            if (expected_stats.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual %0h %0h",
                         $time, m_tuser, m_tdata);
                errors++;
            end
            else
            begin
                want = expected_stats.pop_front();
                check_field("short_frame", 64'(want.short_frame), 64'(got.short_frame));
                check_field("mac_slot", 64'(want.mac_slot), 64'(got.mac_slot));
                check_field("mac_packets", 64'(want.mac_packets), 64'(got.mac_packets));
                check_field("mac_is_new", 64'(want.mac_is_new), 64'(got.mac_is_new));
                check_field("src_ip_is_new", 64'(want.src_ip_is_new),
                            64'(got.src_ip_is_new));
                check_field("dst_ip_is_new", 64'(want.dst_ip_is_new),
                            64'(got.dst_ip_is_new));
                check_field("distinct_macs", 64'(want.distinct_macs),
                            64'(got.distinct_macs));
                check_field("distinct_ips", 64'(want.distinct_ips), 64'(got.distinct_ips));
                check_field("tcp_total", 64'(want.tcp_total), 64'(got.tcp_total));
                check_field("udp_total", 64'(want.udp_total), 64'(got.udp_total));
                check_field("entry_value", 64'(want.entry_value), 64'(got.entry_value));
                check_field("full_flags", 64'(want.full_flags), 64'(got.full_flags));
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("per_mac_ip_traffic_stats: mismatch");
                    $finish;
                end
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        int i;
        int p;
        for (i = 0; i < MAC_POOL; i++)
            mac_pool[i] = 48'({$urandom(), $urandom()});
        for (i = 0; i < IP_POOL; i++)
            ip_pool[i] = $urandom();
        mac_pool[0] = 48'h0;
        mac_pool[1] = 48'hFFFF_FFFF_FFFF;
        ip_pool[0] = 32'h0;
        ip_pool[1] = 32'hFFFF_FFFF;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: short frames, empty-table reads, zero and all-ones addresses,
        // non-IPv4, same source and destination, other protocols, unused kind
        add_header(16'd0, 48'hFFFF_FFFF_FFFF, ptstat_pkg::ETHERTYPE_IPV4, 32'h1, 32'h2,
                   ptstat_pkg::PROTO_TCP);
        add_header(16'd13, 48'h0, ptstat_pkg::ETHERTYPE_IPV4, 32'h0, 32'h0,
                   ptstat_pkg::PROTO_UDP);
        add_read(ptstat_pkg::KIND_READ_MAC, 6'd0);
        add_read(ptstat_pkg::KIND_READ_IP, 6'd63);
        add_header(16'd14, 48'h0, ETHERTYPE_IPV6, 32'h1, 32'h2, ptstat_pkg::PROTO_TCP);
        add_header(16'hFFFF, 48'hFFFF_FFFF_FFFF, ptstat_pkg::ETHERTYPE_IPV4, 32'h0,
                   32'hFFFF_FFFF, ptstat_pkg::PROTO_TCP);
        add_header(16'd64, 48'h0, ptstat_pkg::ETHERTYPE_IPV4, 32'h0A00_0001, 32'h0A00_0001,
                   ptstat_pkg::PROTO_UDP);
        add_header(16'd60, 48'h0200_0000_0001, ptstat_pkg::ETHERTYPE_IPV4, 32'h0,
                   32'hFFFF_FFFF, PROTO_ICMP);
        add_header(16'd1518, 48'h0200_0000_0001, 16'hFFFF, 32'hC0A8_0001, 32'h0,
                   ptstat_pkg::PROTO_UDP);
        add_header(16'd100, 48'hFFFF_FFFF_FFFF, ptstat_pkg::ETHERTYPE_IPV4, 32'hC0A8_0001,
                   32'h0A00_0001, 8'hFF);
        add_read(KIND_UNUSED, 6'd63);
        add_read(ptstat_pkg::KIND_READ_MAC, 6'd0);
        add_read(ptstat_pkg::KIND_READ_MAC, 6'd1);
        add_read(ptstat_pkg::KIND_READ_MAC, 6'd2);
        add_read(ptstat_pkg::KIND_READ_MAC, 6'd3);
        add_read(ptstat_pkg::KIND_READ_IP, 6'd0);
        add_read(ptstat_pkg::KIND_READ_IP, 6'd1);
        add_read(ptstat_pkg::KIND_READ_IP, 6'd3);
        add_read(ptstat_pkg::KIND_READ_IP, 6'd4);
        add_read(ptstat_pkg::KIND_READ_IP, 6'd63);
        wait_drained();

        // Random phases, fully drained between them
        for (p = 0; p < 3; p++)
        begin
            send_idle = (p == 0) ? 13 : (p == 1) ? 53 : 0;
            recv_idle = (p == 0) ? 53 : (p == 1) ? 13 : 0;
            for (i = 0; i < PHASE_ITEMS; i++)
                pending_items.push_back(random_item());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && expected_stats.size() == 0)
            $display("per_mac_ip_traffic_stats: match");
        else
            $display("per_mac_ip_traffic_stats: mismatch");
        $finish;
    end

endmodule

### filelist.f
design/ptstat_pkg.sv
design/ptstat_ram.sv
design/ptstat_engine.sv
design/per_mac_ip_traffic_stats.sv
verif/per_mac_ip_traffic_stats_test.sv
